// ===== hw/rtl/slpd_pkg.sv =====
// shared types, codes and constants for the string list decoder
package slpd_pkg;

  // default configuration of the block
  localparam int SLPD_MAX_STRINGS = 32;
  localparam int SLPD_LENGTH_BITS = 16;

  // most results that one input item may cause
  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // header characters
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // byte class worked out by the front
  typedef enum logic [1:0] {
    CLS_DIGIT = 2'd0,
    CLS_SPACE = 2'd1,
    CLS_OTHER = 2'd2
  } cls_t;

  // one queued item
  typedef struct packed {
    cls_t       cls;
    logic [7:0] data;
  } tok_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  // error codes
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_NUMBER = 2'd1,
    ERR_COUNT  = 2'd2,
    ERR_LENGTH = 2'd3
  } err_t;

  // one result, without its end-of-run mark
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [4:0] idx;
    logic       los;
    logic       lom;
    err_t       err;
  } res_t;

endpackage

// ===== hw/rtl/slpd_ifs.sv =====
// valid/ready channel interfaces for the input and result streams

interface slpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface slpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] out_byte;
  logic [4:0] string_index;
  logic       last_of_string;
  logic       last_of_message;
  logic [1:0] error_code;
  logic       last_of_run;

  modport source (
    output valid, output result_kind, output out_byte, output string_index,
    output last_of_string, output last_of_message, output error_code,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input result_kind, input out_byte, input string_index,
    input last_of_string, input last_of_message, input error_code,
    input last_of_run, output ready
  );
endinterface

// ===== hw/rtl/string_list_length_prefix_decoder_core.sv =====
// Length-prefixed string list decoder. Bytes enter on in_ch, one per accepted
// item, and land in a two-entry queue; the back end reads a decimal count, then
// that many decimal lengths into an internal table, then tags payload bytes
// with their string index and end-of-string and end-of-message marks on out_ch.
// Header bytes and payload bytes are taken at one byte per cycle while results
// can move on and no table lookup is pending. Each string boundary takes an
// extra back-end step (B_CHK) to look up the next length in the table
// (registered-read memory), each empty-string marker takes a step of its own,
// and the end of the header passes through B_RD and then B_CHK before the first
// lookup result is used. A result waits in a holding register until its
// last-of-run mark is known, and then moves to the output register.
// Errors (bad or empty number, count over MAX_STRINGS, length too wide for LENGTH_BITS)
// give one error result and the decoder then waits for a new count. The length
// table holds no reset value; every entry is written in the header before the
// payload reads it.
module string_list_length_prefix_decoder_core
  import slpd_pkg::*;
#(
  parameter int MAX_STRINGS = SLPD_MAX_STRINGS,
  parameter int LENGTH_BITS = SLPD_LENGTH_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  slpd_in_if.sink    in_ch,
  slpd_out_if.source out_ch
);

  logic q_valid;
  tok_t q_tok;
  logic q_pop;

  // byte intake and queue
  slpd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_tok   (q_tok),
    .q_pop   (q_pop)
  );

  // decode engine and result output
  slpd_back #(
    .MAX_STRINGS (MAX_STRINGS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_tok   (q_tok),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== hw/rtl/slpd_ram.sv =====
// generic single-port-write, registered-read ram
module slpd_ram
  import slpd_pkg::*;
#(
  parameter int WIDTH = SLPD_LENGTH_BITS,
  parameter int DEPTH = SLPD_MAX_STRINGS
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/slpd_front.sv =====
// front end: takes bytes, classifies them and queues them for the back end
module slpd_front
  import slpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  slpd_in_if.sink    in_ch,
  output logic       q_valid,
  output tok_t       q_tok,
  input  logic       q_pop
);

  localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW = $clog2(Q_DEPTH + 1);

  tok_t           q_mem_r [Q_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  tok_t           tok_in;
  logic           push;

  // classify the incoming byte
  always_comb begin
    if (in_ch.data_byte >= CHAR_ZERO && in_ch.data_byte <= CHAR_NINE) begin
      tok_in.cls = CLS_DIGIT;
    end else if (in_ch.data_byte == SPACE_BYTE) begin
      tok_in.cls = CLS_SPACE;
    end else begin
      tok_in.cls = CLS_OTHER;
    end
    tok_in.data = in_ch.data_byte;
  end

  // queue handshake
  assign in_ch.ready = (cnt_r != QCW'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_tok       = q_mem_r[rd_ptr_r];

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= tok_in;
    end
  end

endmodule

// ===== hw/rtl/slpd_back.sv =====
// back end: header parsing, length table, payload tagging and result output
module slpd_back
  import slpd_pkg::*;
#(
  parameter int MAX_STRINGS = SLPD_MAX_STRINGS,
  parameter int LENGTH_BITS = SLPD_LENGTH_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  tok_t       q_tok,
  output logic       q_pop,
  slpd_out_if.source out_ch
);

  localparam int CW    = $clog2(MAX_STRINGS + 1);
  localparam int IW    = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
  localparam int DEPTH = 1 << IW;
  localparam int AW    = (LENGTH_BITS > 7) ? LENGTH_BITS : 7;
  localparam int NXW   = AW + 4;
  localparam logic [NXW-1:0] LEN_MAX = NXW'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [NXW-1:0] CNT_MAX = NXW'(MAX_STRINGS);

  typedef enum logic [2:0] {
    PH_COUNT   = 3'b001,
    PH_LENGTHS = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    B_RUN = 3'b001,
    B_RD  = 3'b010,
    B_CHK = 3'b100
  } bst_t;

  bst_t                 bst_r, bst_nxt;
  phase_t               phase_r, phase_nxt;
  logic [AW-1:0]        acc_r, acc_nxt;
  logic                 dig_r, dig_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        hp_r, hp_nxt;
  logic [CW-1:0]        cur_r, cur_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic                 start_r, start_nxt;
  logic                 cont_r, cont_nxt;
  logic [RES_CNT_W-1:0] n_r, n_nxt;

  res_t                 hold_r;
  logic                 hold_v_r, hold_fin_r;
  res_t                 out_r;
  logic                 out_lr_r, out_v_r;

  logic [LENGTH_BITS-1:0] rd_data;
  logic [LENGTH_BITS-1:0] rem_m1;
  logic [RES_CNT_W-1:0] n_eff;
  logic                 n_ok;
  logic [NXW-1:0]       acc_ext, next_num;
  logic [CW-1:0]        cur_inc, hp_inc;
  logic [IW-1:0]        rd_addr;
  logic                 emit_req, step_end, pop_c, we_c, restart;
  res_t                 emit_res;
  logic                 o_free, slot, advance, emit_do, move;

  // low five bits of a string position
  function automatic logic [4:0] idx5(input logic [CW-1:0] v);
    logic [CW+4:0] w;
    w = {5'b0, v};
    return w[4:0];
  endfunction

  // length table
  slpd_ram #(
    .WIDTH (LENGTH_BITS),
    .DEPTH (DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (we_c && advance),
    .waddr (hp_r[IW-1:0]),
    .wdata (acc_r[LENGTH_BITS-1:0]),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // shared arithmetic
  always_comb begin
    acc_ext  = {4'b0, acc_r};
    next_num = (acc_ext << 3) + (acc_ext << 1) + NXW'(q_tok.data[3:0]);
    rem_m1   = rem_r - 1'b1;
    cur_inc  = cur_r + 1'b1;
    hp_inc   = hp_r + 1'b1;
    n_eff    = cont_r ? n_r : '0;
    n_ok     = (n_eff < RES_CNT_W'(MAX_RESULTS));
  end

  // item execution
  always_comb begin
    bst_nxt   = bst_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    dig_nxt   = dig_r;
    cnt_nxt   = cnt_r;
    hp_nxt    = hp_r;
    cur_nxt   = cur_r;
    rem_nxt   = rem_r;
    start_nxt = start_r;
    cont_nxt  = cont_r;
    n_nxt     = n_r;
    emit_req  = 1'b0;
    step_end  = 1'b0;
    pop_c     = 1'b0;
    we_c      = 1'b0;
    restart   = 1'b0;
    emit_res  = '{kind: KIND_PAYLOAD, data: 8'd0, idx: 5'd0, los: 1'b0, lom: 1'b0,
                  err: ERR_NONE};

    case (bst_r)
      B_RUN: begin
        if (q_valid) begin
          if (phase_r == PH_PAYLOAD) begin
            if (rem_r == '0) begin
              // empty-string markers still owed: drain them before this item
              bst_nxt   = B_CHK;
              start_nxt = 1'b1;
              n_nxt     = '0;
            end else begin
              pop_c        = 1'b1;
              cont_nxt     = 1'b0;
              emit_req     = n_ok;
              emit_res.data = q_tok.data;
              emit_res.idx  = idx5(cur_r);
              if (rem_m1 != '0) begin
                rem_nxt  = rem_m1;
                step_end = 1'b1;
              end else begin
                // last byte of the string
                rem_nxt      = '0;
                cur_nxt      = cur_inc;
                emit_res.los = 1'b1;
                emit_res.lom = (cur_inc >= cnt_r);
                if (cur_inc >= cnt_r) begin
                  restart  = 1'b1;
                  step_end = 1'b1;
                end else begin
                  bst_nxt   = B_CHK;
                  start_nxt = 1'b0;
                  n_nxt     = n_eff + RES_CNT_W'(n_ok);
                end
              end
            end
          end else begin
            pop_c    = 1'b1;
            step_end = 1'b1;
            case (q_tok.cls)
              CLS_DIGIT: begin
                if (phase_r == PH_COUNT && next_num > CNT_MAX) begin
                  emit_req     = 1'b1;
                  emit_res.kind = KIND_ERROR;
                  emit_res.err  = ERR_COUNT;
                  restart      = 1'b1;
                end else if (phase_r != PH_COUNT && next_num > LEN_MAX) begin
                  emit_req     = 1'b1;
                  emit_res.kind = KIND_ERROR;
                  emit_res.idx  = idx5(hp_r);
                  emit_res.err  = ERR_LENGTH;
                  restart      = 1'b1;
                end else begin
                  acc_nxt = next_num[AW-1:0];
                  dig_nxt = 1'b1;
                end
              end
              CLS_SPACE: begin
                if (!dig_r) begin
                  // empty number
                  emit_req     = 1'b1;
                  emit_res.kind = KIND_ERROR;
                  emit_res.idx  = (phase_r == PH_COUNT) ? 5'd0 : idx5(hp_r);
                  emit_res.err  = ERR_NUMBER;
                  restart      = 1'b1;
                end else if (phase_r == PH_COUNT) begin
                  if (acc_r == '0) begin
                    emit_req     = 1'b1;
                    emit_res.kind = KIND_NONE;
                    emit_res.lom  = 1'b1;
                    restart      = 1'b1;
                  end else begin
                    cnt_nxt   = acc_r[CW-1:0];
                    phase_nxt = PH_LENGTHS;
                    hp_nxt    = '0;
                    acc_nxt   = '0;
                    dig_nxt   = 1'b0;
                  end
                end else begin
                  // store one length
                  we_c    = 1'b1;
                  hp_nxt  = hp_inc;
                  acc_nxt = '0;
                  dig_nxt = 1'b0;
                  if (hp_inc >= cnt_r) begin
                    phase_nxt = PH_PAYLOAD;
                    cur_nxt   = '0;
                    bst_nxt   = B_RD;
                    start_nxt = 1'b0;
                    n_nxt     = '0;
                    step_end  = 1'b0;
                  end
                end
              end
              default: begin
                emit_req     = 1'b1;
                emit_res.kind = KIND_ERROR;
                emit_res.idx  = (phase_r == PH_COUNT) ? 5'd0 : idx5(hp_r);
                emit_res.err  = ERR_NUMBER;
                restart      = 1'b1;
              end
            endcase
          end
        end
      end
      B_RD: begin
        // wait for the table read after the last length was written
        bst_nxt = B_CHK;
      end
      B_CHK: begin
        if (cur_r >= cnt_r) begin
          restart  = 1'b1;
          bst_nxt  = B_RUN;
          step_end = 1'b1;
          pop_c    = start_r;
        end else if (rd_data == '0) begin
          if (n_r < RES_CNT_W'(MAX_RESULTS)) begin
            emit_req     = 1'b1;
            emit_res.kind = KIND_EMPTY;
            emit_res.idx  = idx5(cur_r);
            emit_res.los  = 1'b1;
            emit_res.lom  = (cur_inc >= cnt_r);
            cur_nxt      = cur_inc;
            n_nxt        = n_r + 1'b1;
          end else begin
            // result limit reached: remaining markers wait for the next item
            rem_nxt  = '0;
            bst_nxt  = B_RUN;
            step_end = 1'b1;
            pop_c    = start_r;
          end
        end else begin
          rem_nxt = rd_data;
          bst_nxt = B_RUN;
          if (start_r) begin
            cont_nxt = 1'b1;
          end else begin
            step_end = 1'b1;
          end
        end
      end
      default: begin
        bst_nxt = B_RUN;
      end
    endcase

    // back to waiting for a count
    if (restart) begin
      phase_nxt = PH_COUNT;
      acc_nxt   = '0;
      dig_nxt   = 1'b0;
      cnt_nxt   = '0;
      hp_nxt    = '0;
      cur_nxt   = '0;
      rem_nxt   = '0;
      cont_nxt  = 1'b0;
    end
  end

  // result hold and output stage handshake
  assign o_free  = !out_v_r || out_ch.ready;
  assign slot    = !hold_v_r || o_free;
  assign advance = !emit_req || slot;
  assign emit_do = advance && emit_req;
  assign move    = hold_v_r && o_free && (hold_fin_r || emit_do);
  assign q_pop   = pop_c && advance;

  // table is read at the next string pointer when the step advances
  always_comb begin
    logic [CW-1:0] a;
    a       = advance ? cur_nxt : cur_r;
    rd_addr = a[IW-1:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r      <= B_RUN;
      phase_r    <= PH_COUNT;
      acc_r      <= '0;
      dig_r      <= 1'b0;
      cnt_r      <= '0;
      hp_r       <= '0;
      cur_r      <= '0;
      rem_r      <= '0;
      start_r    <= 1'b0;
      cont_r     <= 1'b0;
      n_r        <= '0;
      hold_v_r   <= 1'b0;
      hold_fin_r <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (advance) begin
        bst_r   <= bst_nxt;
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        dig_r   <= dig_nxt;
        cnt_r   <= cnt_nxt;
        hp_r    <= hp_nxt;
        cur_r   <= cur_nxt;
        rem_r   <= rem_nxt;
        start_r <= start_nxt;
        cont_r  <= cont_nxt;
        n_r     <= n_nxt;
      end
      if (emit_do) begin
        hold_v_r   <= 1'b1;
        hold_fin_r <= step_end;
      end else if (move) begin
        hold_v_r   <= 1'b0;
        hold_fin_r <= 1'b0;
      end else if (advance && step_end && hold_v_r) begin
        hold_fin_r <= 1'b1;
      end
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit_do) begin
      hold_r <= emit_res;
    end
    if (move) begin
      out_r    <= hold_r;
      out_lr_r <= hold_fin_r;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.result_kind     = out_r.kind;
  assign out_ch.out_byte        = out_r.data;
  assign out_ch.string_index    = out_r.idx;
  assign out_ch.last_of_string  = out_r.los;
  assign out_ch.last_of_message = out_r.lom;
  assign out_ch.error_code      = out_r.err;
  assign out_ch.last_of_run     = out_lr_r;

endmodule

// ===== verif/string_list_length_prefix_decoder_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the length-prefixed string list decoder core
module string_list_length_prefix_decoder_core_tb;
  import slpd_pkg::*;

  localparam int          TAB_DEPTH   = 64;
  localparam int unsigned LEN_MAX     = 32'((64'd1 << SLPD_LENGTH_BITS) - 64'd1);
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          IDLE_PCT    = 11;
  localparam int          STREAM_LEN  = 265;

  // decoder phases of the predictor
  typedef enum logic [1:0] {
    DEC_COUNT,
    DEC_LENGTHS,
    DEC_PAYLOAD
  } dec_phase_t;

  // ways a broken message goes wrong
  typedef enum logic [1:0] {
    BRK_BYTE,
    BRK_GAP,
    BRK_COUNT,
    BRK_LENGTH
  } brk_t;

  // one decoded result with its end-of-run mark
  typedef struct packed {
    res_t r;
    logic lor;
  } exp_res_t;

  logic clk;
  logic rst_n;

  slpd_in_if  in_if ();
  slpd_out_if out_if ();

  string_list_length_prefix_decoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // encoded bytes still to send and decoded results still to arrive
  logic [7:0] stream_q [$];
  exp_res_t   decoded_q [$];

  int  in_taken   = 0;
  int  n_fail     = 0;
  int  cycles     = 0;
  int  hold_left  = 0;
  bit  hold_done  = 0;
  bit  drain_wait = 0;
  bit  drain_done = 0;
  logic quiet;

  // no idling on either side for a stretch in the middle
  assign quiet = (in_taken >= 120) && (in_taken < 200);

  // decoder state as predicted
  dec_phase_t                  dec_phase;
  int unsigned                 num_acc;
  bit                          have_digit;
  int unsigned                 str_total;
  int unsigned                 hdr_pos;
  logic [SLPD_LENGTH_BITS-1:0] len_tab [TAB_DEPTH];
  int unsigned                 str_cur;
  int unsigned                 bytes_left;
  int                          n_made;

  always #4 clk = ~clk;

  function automatic string fmt_res(exp_res_t x);
    return $sformatf("kind=%0d byte=%02h idx=%0d los=%b lom=%b err=%0d run=%b",
                     x.r.kind, x.r.data, x.r.idx, x.r.los, x.r.lom, x.r.err, x.lor);
  endfunction

  function automatic void add_result(kind_t k, logic [7:0] d, int unsigned idx,
                                     logic los, logic lom, err_t e);
    exp_res_t x;
    if (n_made >= MAX_RESULTS) return;
    x.r.kind = k;
    x.r.data = d;
    x.r.idx  = idx[4:0];
    x.r.los  = los;
    x.r.lom  = lom;
    x.r.err  = e;
    x.lor    = 1'b0;
    decoded_q.insert(decoded_q.size(), x);
    n_made++;
  endfunction

  function automatic void restart_decoder();
    dec_phase  = DEC_COUNT;
    num_acc    = 0;
    have_digit = 0;
    str_total  = 0;
    hdr_pos    = 0;
    str_cur    = 0;
    bytes_left = 0;
  endfunction

  function automatic void flag_error(int unsigned idx, err_t e);
    add_result(KIND_ERROR, 8'h00, idx, 1'b0, 1'b0, e);
    restart_decoder();
  endfunction

  // markers for the run of zero-length strings at the current position
  function automatic void emit_empties();
    while (str_cur < str_total && str_cur < TAB_DEPTH && len_tab[str_cur] == 0 &&
           n_made < MAX_RESULTS) begin
      str_cur++;
      add_result(KIND_EMPTY, 8'h00, str_cur - 1, 1'b1, str_cur >= str_total, ERR_NONE);
    end
    if (str_cur >= str_total || str_cur >= TAB_DEPTH) restart_decoder();
    else if (len_tab[str_cur] != 0) bytes_left = 32'(len_tab[str_cur]);
    else bytes_left = 0;
  endfunction

  // work out every result that one accepted byte causes
  function automatic void predict_byte(logic [7:0] b);
    int unsigned nxt;
    int unsigned idx;
    bit          done;
    n_made = 0;
    done   = 0;
    // markers left over from the previous byte swallow this one
    if (dec_phase == DEC_PAYLOAD && bytes_left == 0) begin
      emit_empties();
      if (dec_phase != DEC_PAYLOAD || bytes_left == 0) done = 1;
    end
    if (!done) begin
      if (dec_phase == DEC_PAYLOAD) begin
        idx = str_cur;
        bytes_left--;
        if (bytes_left != 0) begin
          add_result(KIND_PAYLOAD, b, idx, 1'b0, 1'b0, ERR_NONE);
        end else begin
          str_cur++;
          add_result(KIND_PAYLOAD, b, idx, 1'b1, str_cur >= str_total, ERR_NONE);
          emit_empties();
        end
      end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
        nxt = num_acc * 10 + 32'(b - CHAR_ZERO);
        if (dec_phase == DEC_COUNT && nxt > SLPD_MAX_STRINGS) begin
          flag_error(0, ERR_COUNT);
        end else if (dec_phase == DEC_LENGTHS && nxt > LEN_MAX) begin
          flag_error(hdr_pos, ERR_LENGTH);
        end else begin
          num_acc    = nxt;
          have_digit = 1;
        end
      end else if (b == SPACE_BYTE) begin
        if (!have_digit) begin
          flag_error((dec_phase == DEC_COUNT) ? 0 : hdr_pos, ERR_NUMBER);
        end else if (dec_phase == DEC_COUNT) begin
          str_total  = num_acc;
          num_acc    = 0;
          have_digit = 0;
          if (str_total == 0) begin
            add_result(KIND_NONE, 8'h00, 0, 1'b0, 1'b1, ERR_NONE);
            restart_decoder();
          end else begin
            dec_phase = DEC_LENGTHS;
            hdr_pos   = 0;
          end
        end else begin
          if (hdr_pos < TAB_DEPTH) len_tab[hdr_pos] = num_acc[SLPD_LENGTH_BITS-1:0];
          hdr_pos++;
          num_acc    = 0;
          have_digit = 0;
          if (hdr_pos >= str_total) begin
            dec_phase = DEC_PAYLOAD;
            str_cur   = 0;
            emit_empties();
          end
        end
      end else begin
        flag_error((dec_phase == DEC_COUNT) ? 0 : hdr_pos, ERR_NUMBER);
      end
    end
    if (n_made > 0) decoded_q[decoded_q.size() - 1].lor = 1'b1;
  endfunction

  // stimulus helpers
  function automatic void put_byte(logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] r;
    r = 8'($urandom_range(255));
    return r;
  endfunction

  function automatic logic [7:0] bad_byte();
    logic [7:0] r;
    r = rand_byte();
    while ((r >= CHAR_ZERO && r <= CHAR_NINE) || r == SPACE_BYTE) r = rand_byte();
    return r;
  endfunction

  task automatic push_number(input int unsigned v, input int unsigned zeros);
    string digits;
    digits = $sformatf("%0d", v);
    repeat (zeros) put_byte(CHAR_ZERO);
    for (int i = 0; i < digits.len(); i++) put_byte(digits[i]);
  endtask

  // one random message, mostly well formed, sometimes broken in the header
  task automatic gen_message();
    int unsigned pick;
    int unsigned cnt;
    int unsigned cut;
    int unsigned val;
    int unsigned lens [$];
    brk_t        fault;
    pick = $urandom_range(99);
    if (pick < 72) begin
      pick = $urandom_range(99);
      if (pick < 6) cnt = 0;
      else if (pick < 10) cnt = SLPD_MAX_STRINGS;
      else cnt = $urandom_range(1, 5);
      push_number(cnt, ($urandom_range(7) == 0) ? 1 : 0);
      put_byte(SPACE_BYTE);
      for (int i = 0; i < cnt; i++) begin
        pick = $urandom_range(99);
        if (cnt == SLPD_MAX_STRINGS) val = (pick < 75) ? 0 : 1;
        else if (pick < 30) val = 0;
        else if (pick < 85) val = $urandom_range(1, 4);
        else val = $urandom_range(5, 12);
        lens.insert(lens.size(), val);
        push_number(val, ($urandom_range(9) == 0) ? 1 : 0);
        put_byte(SPACE_BYTE);
      end
      foreach (lens[i]) repeat (lens[i]) put_byte(rand_byte());
    end else begin
      fault = brk_t'($urandom_range(3));
      if (fault == BRK_COUNT) begin
        push_number($urandom_range(SLPD_MAX_STRINGS + 1, 99), 0);
      end else begin
        // header prefix that stops short of the payload
        cnt = $urandom_range(1, 6);
        cut = $urandom_range(0, cnt - 1);
        if (fault == BRK_LENGTH || $urandom_range(3) != 0) begin
          push_number(cnt, 0);
          put_byte(SPACE_BYTE);
          repeat (cut) begin
            push_number($urandom_range(12), 0);
            put_byte(SPACE_BYTE);
          end
        end
        case (fault)
          BRK_BYTE: begin
            if ($urandom_range(1) != 0) put_byte(CHAR_ZERO + 8'($urandom_range(9)));
            put_byte(bad_byte());
          end
          BRK_GAP: put_byte(SPACE_BYTE);
          default: begin
            if ($urandom_range(1) != 0) begin
              push_number($urandom_range(LEN_MAX + 1, 99999), 0);
            end else begin
              push_number(LEN_MAX, 0);
              put_byte(bad_byte());
            end
          end
        endcase
      end
    end
  endtask

  // driver: offers queued bytes and predicts on every accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid     <= 1'b0;
      in_if.data_byte <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_byte(in_if.data_byte);
        in_taken <= in_taken + 1;
      end
      // one pause late in the run until all results are out
      if (drain_wait) begin
        if (decoded_q.size() == 0) begin
          drain_wait = 0;
          drain_done = 1;
        end
      end else if (!drain_done && in_taken >= 240) begin
        drain_wait = 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (stream_q.size() != 0 && !drain_wait &&
            (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          in_if.valid     <= 1'b1;
          in_if.data_byte <= stream_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off so the input backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && in_taken >= 60) begin
      hold_done    <= 1'b1;
      hold_left    <= 80;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: check each accepted result against the oldest prediction
  always @(posedge clk) begin
    exp_res_t got;
    exp_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.r.kind = kind_t'(out_if.result_kind);
      got.r.data = out_if.out_byte;
      got.r.idx  = out_if.string_index;
      got.r.los  = out_if.last_of_string;
      got.r.lom  = out_if.last_of_message;
      got.r.err  = err_t'(out_if.error_code);
      got.lor    = out_if.last_of_run;
      if (decoded_q.size() == 0) begin
        // keep the log short once things go badly wrong
        if (n_fail < 40)
          $display("%0t: unexpected result, expected none, actual %s", $time, fmt_res(got));
        n_fail++;
      end else begin
        want = decoded_q.pop_front();
        if (got !== want) begin
          if (n_fail < 40)
            $display("%0t: mismatch, expected %s, actual %s",
                     $time, fmt_res(want), fmt_res(got));
          n_fail++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    out_if.ready    = 1'b0;
    restart_decoder();
    foreach (len_tab[i]) len_tab[i] = '0;

    // directed: zero count with a leading zero
    push_number(0, 1);
    put_byte(SPACE_BYTE);
    // empty string first, then a one-byte string with a padded length
    push_number(2, 0);
    put_byte(SPACE_BYTE);
    push_number(0, 0);
    put_byte(SPACE_BYTE);
    push_number(1, 1);
    put_byte(SPACE_BYTE);
    put_byte(8'hFF);
    // non-digit in the count, then an empty count
    put_byte(8'h00);
    put_byte(SPACE_BYTE);
    // count over the limit
    push_number(SLPD_MAX_STRINGS + 1, 0);
    // length overflow on its last digit
    push_number(1, 0);
    put_byte(SPACE_BYTE);
    push_number(70000, 0);
    // non-digit in the length list
    push_number(1, 0);
    put_byte(SPACE_BYTE);
    put_byte(CHAR_ZERO - 8'd1);

    // a full list of empty strings, then random mixed messages
    push_number(SLPD_MAX_STRINGS, 0);
    put_byte(SPACE_BYTE);
    repeat (SLPD_MAX_STRINGS) begin
      push_number(0, 0);
      put_byte(SPACE_BYTE);
    end
    while (stream_q.size() < STREAM_LEN) gen_message();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (stream_q.size() != 0 || in_if.valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_fail == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/slpd_pkg.sv
hw/rtl/slpd_ifs.sv
hw/rtl/slpd_ram.sv
hw/rtl/slpd_front.sv
hw/rtl/slpd_back.sv
hw/rtl/string_list_length_prefix_decoder_core.sv
verif/string_list_length_prefix_decoder_core_tb.sv
